### hdl/assert_macros.svh
// assertion macros for the link failover retry sequencer
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed");

// antecedent implies consequent in the cycle after
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/lfrs_pkg.sv
// types and constants of the link failover retry sequencer
// no dependencies
`default_nettype none

package lfrs_pkg;

	typedef enum logic [1:0] {
		CMD_NONE     = 2'd0,
		CMD_START    = 2'd1,
		CMD_FALLBACK = 2'd2
	} command_t;

	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t REG_SLOT_MASK   = 3'd0;
	localparam cfg_index_t REG_CHECK_IVL   = 3'd1;
	localparam cfg_index_t REG_TRY_TIMEOUT = 3'd2;
	localparam cfg_index_t REG_RETRY_DELAY = 3'd3;
	localparam cfg_index_t REG_MAX_FAIL    = 3'd4;

	localparam logic [3:0]  RST_SLOT_MASK   = 4'd0;
	localparam logic [31:0] RST_CHECK_IVL   = 32'd5000;
	localparam logic [31:0] RST_TRY_TIMEOUT = 32'd10000;
	localparam logic [31:0] RST_RETRY_DELAY = 32'd30000;
	localparam logic [7:0]  RST_MAX_FAIL    = 8'd3;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        link_up;
	} item_t;

	typedef struct packed {
		command_t    command;
		logic [1:0]  slot;
		logic        drop_first;
		logic        reconnected;
		logic [7:0]  fail_cycles;
		logic        fallback_mode;
	} result_t;

	typedef struct packed {
		logic [3:0]  slot_mask;
		logic [31:0] check_interval_ms;
		logic [31:0] try_timeout_ms;
		logic [31:0] retry_delay_ms;
		logic [7:0]  max_fail_cycles;
	} cfg_t;

	typedef struct packed {
		logic        outage_active;
		logic        trying_valid;
		logic [1:0]  trying_slot;
		logic [31:0] attempt_start;
		logic [31:0] last_check;
		logic [7:0]  fail_count;
		logic        fallback_flag;
	} seq_state_t;

endpackage

`default_nettype wire

### hdl/lfrs_step.sv
// single-pass step logic: next sequencer state and result for one tick
// depends on lfrs_pkg
`default_nettype none

module lfrs_step #(
	parameter int NUM_SLOTS = 4
) (
	input  lfrs_pkg::cfg_t       cfg,
	input  lfrs_pkg::seq_state_t cur,
	input  lfrs_pkg::item_t      item,
	output lfrs_pkg::seq_state_t nxt,
	output lfrs_pkg::result_t    res
);
	import lfrs_pkg::*;

	logic [3:0] elig;
	logic       found;
	logic [1:0] sel;
	logic       tv;
	logic       go;
	logic [7:0] fc_inc;

	always_comb begin
		nxt = cur;
		res = '0;
		res.command = CMD_NONE;
		go = 1'b0;
		tv = 1'b0;
		elig = '0;
		found = 1'b0;
		sel = '0;
		fc_inc = (cur.fail_count != 8'hFF) ? cur.fail_count + 8'd1 : cur.fail_count;

		if (!cur.fallback_flag) begin
			if (item.link_up) begin
				if (cur.outage_active) begin
					nxt.outage_active = 1'b0;
					nxt.fail_count = '0;
					nxt.trying_valid = 1'b0;
					res.reconnected = 1'b1;
				end
			end else begin
				go = 1'b1;
				tv = cur.trying_valid;
				if (!cur.outage_active) begin
					if ((item.now_ms - cur.last_check) < cfg.check_interval_ms) begin
						go = 1'b0;
					end else begin
						nxt.last_check = item.now_ms;
						nxt.outage_active = 1'b1;
						nxt.trying_valid = 1'b0;
						tv = 1'b0;
					end
				end
				if (go && tv) begin
					if ((item.now_ms - cur.attempt_start) < cfg.try_timeout_ms) begin
						go = 1'b0;
					end else begin
						res.drop_first = 1'b1;
					end
				end

				// enabled slots after the one being tried (all enabled when none is); lowest wins
				for (int i = 0; i < 4; i++) begin
					elig[i] = cfg.slot_mask[i] && (i < NUM_SLOTS) &&
						(!tv || (3'(i) > {1'b0, cur.trying_slot}));
				end
				for (int i = 3; i >= 0; i--) begin
					if (elig[i]) begin
						found = 1'b1;
						sel = 2'(i);
					end
				end

				if (go) begin
					if (found) begin
						nxt.trying_valid = 1'b1;
						nxt.trying_slot = sel;
						nxt.attempt_start = item.now_ms;
						res.command = CMD_START;
						res.slot = sel;
					end else begin
						nxt.trying_valid = 1'b0;
						nxt.fail_count = fc_inc;
						nxt.outage_active = 1'b0;
						if (fc_inc >= cfg.max_fail_cycles) begin
							nxt.fallback_flag = 1'b1;
							res.command = CMD_FALLBACK;
						end else begin
							nxt.last_check = item.now_ms + cfg.retry_delay_ms -
								cfg.check_interval_ms;
						end
					end
				end
			end
		end

		res.fail_cycles = nxt.fail_count;
		res.fallback_mode = nxt.fallback_flag;
	end

endmodule

`default_nettype wire

### hdl/link_failover_retry_sequencer.sv
// link failover retry sequencer top level: registers, handshakes, configuration
// depends on lfrs_pkg, lfrs_step and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Takes one tick transaction per clock (timestamp and link-up flag) unless the
// result register is stalled, and returns exactly one result transaction per
// tick. A tick is held in an input register; once the result register is empty
// or being read, the single-pass step logic updates the sequencer state and the
// result register and raises result_valid. Throughput is one transaction per
// cycle while result_ready stays high. The step logic is one 32-bit subtract and
// compare per timer, a four-slot priority encoder and an 8-bit saturating count.
// Configuration must be written through cfg_wen/cfg_index/cfg_data only while no
// tick is in flight; the block does not enforce this. Indexes beyond the register
// list are ignored. Fallback mode is sticky until reset.
module link_failover_retry_sequencer #(
	parameter int NUM_SLOTS = 4
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      item_valid,
	output logic                     item_ready,
	input  lfrs_pkg::item_t          item,
	output logic                     result_valid,
	input  wire                      result_ready,
	output lfrs_pkg::result_t        result,
	input  wire                      cfg_wen,
	input  lfrs_pkg::cfg_index_t     cfg_index,
	input  wire               [31:0] cfg_data
);
	import lfrs_pkg::*;

	cfg_t       cfg_q;
	seq_state_t st_q;
	seq_state_t st_nxt;
	item_t      item_s1;
	logic       vld_s1;
	result_t    res_nxt;
	result_t    res_q;
	logic       vld_q;
	logic       adv;

	assign adv = vld_s1 && (!vld_q || result_ready);
	assign item_ready = !vld_s1 || adv;
	assign result_valid = vld_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_mask <= RST_SLOT_MASK;
			cfg_q.check_interval_ms <= RST_CHECK_IVL;
			cfg_q.try_timeout_ms <= RST_TRY_TIMEOUT;
			cfg_q.retry_delay_ms <= RST_RETRY_DELAY;
			cfg_q.max_fail_cycles <= RST_MAX_FAIL;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_SLOT_MASK:   cfg_q.slot_mask <= cfg_data[3:0];
				REG_CHECK_IVL:   cfg_q.check_interval_ms <= cfg_data;
				REG_TRY_TIMEOUT: cfg_q.try_timeout_ms <= cfg_data;
				REG_RETRY_DELAY: cfg_q.retry_delay_ms <= cfg_data;
				REG_MAX_FAIL:    cfg_q.max_fail_cycles <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lfrs_step #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_step (
		.cfg  (cfg_q),
		.cur  (st_q),
		.item (item_s1),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_ready) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (adv) begin
				st_q <= st_nxt;
				vld_q <= 1'b1;
			end else if (result_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	`ASSERT_NEXT(a_fallback_sticky, clk, arst_n, st_q.fallback_flag, st_q.fallback_flag)
	`ASSERT_HOLDS(a_fallback_idle, clk, arst_n,
		!st_q.fallback_flag || (!st_q.outage_active && !st_q.trying_valid))
	`ASSERT_HOLDS(a_try_in_outage, clk, arst_n, !st_q.trying_valid || st_q.outage_active)
	`ASSERT_NEXT(a_adv_result, clk, arst_n, adv, vld_q)

endmodule

`default_nettype wire
